[rtl/dgrw_pkg.sv]
// ----------------------------------------------------------------------------
// dgrw_pkg: shared types and constants of the grid ray walk
// transaction payloads, fixed-point widths and wall character codes
// ----------------------------------------------------------------------------
package dgrw_pkg;

  localparam int GRID_WIDTH    = 64;
  localparam int GRID_HEIGHT   = 64;
  localparam int FRACTION_BITS = 16;

  localparam int CELL_W  = 6;
  localparam int POS_W   = 22;
  localparam int DELTA_W = 32;
  localparam int SIDE_W  = 40;
  localparam int BYTE_W  = 8;

  // wall bytes lie strictly between these two
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

  localparam logic [SIDE_W-1:0] SIDE_MAX = {SIDE_W{1'b1}};

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  // axis codes
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef struct packed {
    logic               action;
    logic [CELL_W-1:0]  cell_x;
    logic [CELL_W-1:0]  cell_y;
    logic [BYTE_W-1:0]  cell_value;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic               dir_x_negative;
    logic               dir_y_negative;
    logic [DELTA_W-1:0] delta_x;
    logic [DELTA_W-1:0] delta_y;
  } in_item_t;

  typedef struct packed {
    logic              hit_axis;
    logic [CELL_W-1:0] hit_x;
    logic [CELL_W-1:0] hit_y;
    logic [SIDE_W-1:0] side_x;
    logic [SIDE_W-1:0] side_y;
    logic              left_map;
  } out_item_t;

endpackage

[rtl/dgrw_ram.sv]
// ----------------------------------------------------------------------------
// dgrw_ram: generic single-port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module dgrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dda_grid_ray_walk.sv]
// ----------------------------------------------------------------------------
// dda_grid_ray_walk: grid ray walk by digital differential analysis
// holds a byte map and walks cast rays cell by cell until a wall or the edge
// ----------------------------------------------------------------------------
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_data_i    | to block
//  out     | out_valid_o, out_ready_i, out_data_o | from block
//
//  a write transaction is taken while idle, leaves the block ready and gives no result
//  a cast runs the setup states S_MULX, S_MULY and S_INIT (shared multiplier,
//  x then y, then saturate), S_STEP then S_CHECK per cell move (side add, then
//  the map read), S_STEP alone for a step that would leave the map, and S_FIN
//  to finish; a walk makes at most GRID_WIDTH + GRID_HEIGHT - 2 moves plus that last step
//  reset clears the sequencer and the result valid; the map is undefined
//  until written
//  a finished result waits in its own register, so writes and the next cast
//  are taken while it stalls; a second finished cast waits for it
//
module dda_grid_ray_walk #(
  parameter int GRID_WIDTH  = dgrw_pkg::GRID_WIDTH,
  parameter int GRID_HEIGHT = dgrw_pkg::GRID_HEIGHT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dgrw_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dgrw_pkg::out_item_t out_data_o
);

  localparam int F      = dgrw_pkg::FRACTION_BITS;
  localparam int CW     = dgrw_pkg::CELL_W;
  localparam int SW     = dgrw_pkg::SIDE_W;
  localparam int DW     = dgrw_pkg::DELTA_W;
  localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  // coordinate registers cover both the 6-bit start and the map extent
  localparam int XW     = ($clog2(GRID_WIDTH) > CW) ? $clog2(GRID_WIDTH) : CW;
  localparam int YW     = ($clog2(GRID_HEIGHT) > CW) ? $clog2(GRID_HEIGHT) : CW;
  // distance from origin to cell boundary, start cell at most 6 bits
  localparam int DIFF_W = CW + F + 1;
  localparam int PROD_W = DIFF_W + DW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULX,
    S_MULY,
    S_INIT,
    S_STEP,
    S_CHECK,
    S_FIN
  } state_e;

  // saturating scale of the initial product
  function automatic logic [SW-1:0] sat_prod(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p >> F;
    return (s > PROD_W'(dgrw_pkg::SIDE_MAX)) ? dgrw_pkg::SIDE_MAX : s[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a,
                                            input logic [DW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + (SW+1)'(b);
    return s[SW] ? dgrw_pkg::SIDE_MAX : s[SW-1:0];
  endfunction

  // initial distance from origin to the first boundary in walk direction
  function automatic logic [DIFF_W-1:0] init_diff(input logic [CW-1:0] cell_idx,
                                                  input logic [dgrw_pkg::POS_W-1:0] pos,
                                                  input logic neg);
    logic [DIFF_W-1:0] lo;
    logic [DIFF_W-1:0] hi;
    logic [DIFF_W-1:0] p;
    lo = DIFF_W'(cell_idx) << F;
    hi = lo + (DIFF_W'(1) << F);
    p  = DIFF_W'(pos);
    if (neg) begin
      return (p > lo) ? (p - lo) : '0;
    end
    return (hi > p) ? (hi - p) : '0;
  endfunction

  state_e                        state_q;
  logic [XW-1:0]                 cx_q;
  logic [YW-1:0]                 cy_q;
  logic [dgrw_pkg::POS_W-1:0]    px_q, py_q;
  logic                          nx_q, ny_q;
  logic [DW-1:0]                 dx_q, dy_q;
  logic [SW-1:0]                 sx_q, sy_q;
  logic [PROD_W-1:0]             prod_q;
  logic                          axis_q, left_q, off_map_q;
  logic                          out_valid_q;
  dgrw_pkg::out_item_t           out_q;

  // ram side
  logic                          ram_we;
  logic [AW-1:0]                 ram_addr;
  logic [dgrw_pkg::BYTE_W-1:0]   ram_rdata;

  // shared multiplier operands
  logic [DIFF_W-1:0]             mul_a;
  logic [DW-1:0]                 mul_b;
  logic [PROD_W-1:0]             mul_p;

  // step decision
  logic                          step_x;
  logic [XW-1:0]                 cx_nxt;
  logic [YW-1:0]                 cy_nxt;
  logic [XW-1:0]                 rx;
  logic [YW-1:0]                 ry;
  logic                          edge_x, edge_y;
  logic                          is_wall;
  logic                          in_fire, out_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // one multiplier serves both axes, x in S_MULX and y in S_MULY
  always_comb begin
    if (state_q == S_MULX) begin
      mul_a = init_diff(cx_q[CW-1:0], px_q, nx_q);
      mul_b = dx_q;
    end else begin
      mul_a = init_diff(cy_q[CW-1:0], py_q, ny_q);
      mul_b = dy_q;
    end
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // ties step along y
  assign step_x = (sx_q < sy_q);
  assign cx_nxt = nx_q ? (cx_q - XW'(1)) : (cx_q + XW'(1));
  assign cy_nxt = ny_q ? (cy_q - YW'(1)) : (cy_q + YW'(1));
  assign edge_x = nx_q ? (cx_q == '0) : (cx_q == XW'(GRID_WIDTH - 1));
  assign edge_y = ny_q ? (cy_q == '0) : (cy_q == YW'(GRID_HEIGHT - 1));
  assign rx     = step_x ? cx_nxt : cx_q;
  assign ry     = step_x ? cy_q : cy_nxt;

  // map port: writes while idle, reads of the stepped-into cell otherwise
  assign ram_we = in_fire && (in_data_i.action == dgrw_pkg::ACT_WRITE) &&
                  (32'(in_data_i.cell_x) < 32'(GRID_WIDTH)) &&
                  (32'(in_data_i.cell_y) < 32'(GRID_HEIGHT));
  always_comb begin
    if (state_q == S_IDLE) begin
      ram_addr = AW'(AW'(in_data_i.cell_y) * AW'(GRID_WIDTH)) + AW'(in_data_i.cell_x);
    end else begin
      ram_addr = AW'(AW'(ry) * AW'(GRID_WIDTH)) + AW'(rx);
    end
  end

  assign is_wall = (ram_rdata > dgrw_pkg::CHAR_ZERO) && (ram_rdata < dgrw_pkg::CHAR_NINE);

  dgrw_ram #(
    .WIDTH (dgrw_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_data_i.cell_value),
    .rdata_o (ram_rdata)
  );

  // sequencer, working registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // in S_FIN a taken result is replaced by the new one
      if (out_fire && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && (in_data_i.action == dgrw_pkg::ACT_CAST)) begin
            cx_q      <= XW'(in_data_i.cell_x);
            cy_q      <= YW'(in_data_i.cell_y);
            px_q      <= in_data_i.pos_x;
            py_q      <= in_data_i.pos_y;
            nx_q      <= in_data_i.dir_x_negative;
            ny_q      <= in_data_i.dir_y_negative;
            dx_q      <= in_data_i.delta_x;
            dy_q      <= in_data_i.delta_y;
            axis_q    <= dgrw_pkg::AXIS_X;
            left_q    <= 1'b0;
            off_map_q <= (32'(in_data_i.cell_x) >= 32'(GRID_WIDTH)) ||
                         (32'(in_data_i.cell_y) >= 32'(GRID_HEIGHT));
            state_q   <= S_MULX;
          end
        end
        S_MULX: begin
          prod_q  <= mul_p;
          state_q <= S_MULY;
        end
        S_MULY: begin
          sx_q    <= sat_prod(prod_q);
          prod_q  <= mul_p;
          state_q <= S_INIT;
        end
        S_INIT: begin
          sy_q <= sat_prod(prod_q);
          if (off_map_q) begin
            left_q  <= 1'b1;
            state_q <= S_FIN;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (step_x) begin
            sx_q   <= sat_add(sx_q, dx_q);
            axis_q <= dgrw_pkg::AXIS_X;
            if (edge_x) begin
              left_q  <= 1'b1;
              state_q <= S_FIN;
            end else begin
              cx_q    <= cx_nxt;
              state_q <= S_CHECK;
            end
          end else begin
            sy_q   <= sat_add(sy_q, dy_q);
            axis_q <= dgrw_pkg::AXIS_Y;
            if (edge_y) begin
              left_q  <= 1'b1;
              state_q <= S_FIN;
            end else begin
              cy_q    <= cy_nxt;
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          state_q <= is_wall ? S_FIN : S_STEP;
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.hit_axis <= axis_q;
            out_q.hit_x    <= cx_q[CW-1:0];
            out_q.hit_y    <= cy_q[CW-1:0];
            out_q.side_x   <= sx_q;
            out_q.side_y   <= sy_q;
            out_q.left_map <= left_q;
            out_valid_q    <= 1'b1;
            state_q        <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // a cast occupies the block from the next cycle on
  a_cast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.action == dgrw_pkg::ACT_CAST)) |=> !in_ready_o)
    else $error("cast accepted but block still ready");

  // a map write leaves the block ready
  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.action == dgrw_pkg::ACT_WRITE)) |=> in_ready_o)
    else $error("map write did not complete in one cycle");

  // a step either reads a cell or ends the walk
  a_step_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |=> ((state_q == S_CHECK) || (state_q == S_FIN)))
    else $error("bad successor of cell step");

  // side distances never shrink across a step
  a_side_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> ((sx_q >= $past(sx_q)) && (sy_q >= $past(sy_q))))
    else $error("side distance decreased");

  // a pending result is not overwritten
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("pending result lost");

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the dda grid ray walk
// loads the cell map with write transactions and casts rays over it; a
// scoreboard keeps its own copy of the map, walks every accepted cast itself
// and compares each returned hit field by field, in order
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1533;
  // receiver hold long enough to fill the result register and the walker
  localparam int HOLD_CYCLES  = 400;
  // longest walk: setup, 126 cell moves, a leaving step and the finish; this covers a trailing cast
  localparam int DRAIN_CYCLES = 300;
  // cycles with no transaction on either channel before giving up
  localparam int STALL_LIMIT  = 4000;

  localparam int GRID_WIDTH    = dgrw_pkg::GRID_WIDTH;
  localparam int GRID_HEIGHT   = dgrw_pkg::GRID_HEIGHT;
  localparam int FRACTION_BITS = dgrw_pkg::FRACTION_BITS;
  localparam int CELL_W        = dgrw_pkg::CELL_W;
  localparam int POS_W         = dgrw_pkg::POS_W;
  localparam int DELTA_W       = dgrw_pkg::DELTA_W;
  localparam int SIDE_W        = dgrw_pkg::SIDE_W;
  localparam int BYTE_W        = dgrw_pkg::BYTE_W;
  localparam int MAP_CELLS     = GRID_WIDTH * GRID_HEIGHT;

  // --------------------------------------------------------------------------
  // scoreboard: map copy, ray walk predictor and queue of expected hits
  // --------------------------------------------------------------------------
  class ray_hit_tracker;
    logic [BYTE_W-1:0]   cells[MAP_CELLS];
    bit                  written[MAP_CELLS];
    dgrw_pkg::out_item_t pending_hits[$];
    int unsigned         mismatch_count;

    function new();
      mismatch_count = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function int pending();
      return pending_hits.size();
    endfunction

    function logic [63:0] clip_side(logic [63:0] v);
      return (v > 64'(dgrw_pkg::SIDE_MAX)) ? 64'(dgrw_pkg::SIDE_MAX) : v;
    endfunction

    // distance from the origin to the first cell border, times delta
    function logic [63:0] start_dist(int cell_idx, logic [POS_W-1:0] pos, logic neg,
                                     logic [DELTA_W-1:0] delta);
      logic [63:0] lo, hi, p, diff;
      lo = 64'(cell_idx) << FRACTION_BITS;
      hi = lo + (64'd1 << FRACTION_BITS);
      p  = 64'(pos);
      // an origin past the cell border it walks toward clamps to zero
      if (neg) diff = (p > lo) ? p - lo : 64'd0;
      else     diff = (hi > p) ? hi - p : 64'd0;
      return clip_side((diff * 64'(delta)) >> FRACTION_BITS);
    endfunction

    // walks one cast over the map copy; returns the index of the first
    // never-written cell the walk would read, or -1 when there is none
    function int trace_ray(dgrw_pkg::in_item_t it, output dgrw_pkg::out_item_t res);
      int          cx, cy, idx, miss;
      logic [63:0] sx, sy;
      bit          done;
      cx   = it.cell_x;
      cy   = it.cell_y;
      sx   = start_dist(cx, it.pos_x, it.dir_x_negative, it.delta_x);
      sy   = start_dist(cy, it.pos_y, it.dir_y_negative, it.delta_y);
      res  = '0;
      res.hit_axis = dgrw_pkg::AXIS_X;
      miss = -1;
      // a start cell off the map makes no step at all
      done = (cx >= GRID_WIDTH) || (cy >= GRID_HEIGHT);
      res.left_map = done;
      while (!done) begin
        // ties go to y
        if (sx < sy) begin
          sx = clip_side(sx + 64'(it.delta_x));
          res.hit_axis = dgrw_pkg::AXIS_X;
          if (it.dir_x_negative ? (cx == 0) : (cx + 1 >= GRID_WIDTH)) res.left_map = 1'b1;
          else cx = it.dir_x_negative ? cx - 1 : cx + 1;
        end else begin
          sy = clip_side(sy + 64'(it.delta_y));
          res.hit_axis = dgrw_pkg::AXIS_Y;
          if (it.dir_y_negative ? (cy == 0) : (cy + 1 >= GRID_HEIGHT)) res.left_map = 1'b1;
          else cy = it.dir_y_negative ? cy - 1 : cy + 1;
        end
        if (res.left_map) begin
          done = 1'b1;
        end else begin
          idx = cy * GRID_WIDTH + cx;
          if (!written[idx]) begin
            miss = idx;
            done = 1'b1;
          end else begin
            done = (cells[idx] > dgrw_pkg::CHAR_ZERO) && (cells[idx] < dgrw_pkg::CHAR_NINE);
          end
        end
      end
      res.hit_x  = CELL_W'(cx);
      res.hit_y  = CELL_W'(cy);
      res.side_x = sx[SIDE_W-1:0];
      res.side_y = sy[SIDE_W-1:0];
      return miss;
    endfunction

    // accepted input transaction: update the map or queue the predicted hit
    function void absorb_item(dgrw_pkg::in_item_t it);
      dgrw_pkg::out_item_t res;
      int                  idx;
      if (it.action == dgrw_pkg::ACT_WRITE) begin
        if ((it.cell_x < GRID_WIDTH) && (it.cell_y < GRID_HEIGHT)) begin
          idx          = int'(it.cell_y) * GRID_WIDTH + int'(it.cell_x);
          cells[idx]   = it.cell_value;
          written[idx] = 1'b1;
        end
      end else begin
        void'(trace_ray(it, res));
        pending_hits.push_back(res);
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
    endtask

    task check_hit(dgrw_pkg::out_item_t got);
      dgrw_pkg::out_item_t want;
      if (pending_hits.size() == 0) begin
        report_mismatch($sformatf("hit %h with no cast waiting", got));
        return;
      end
      want = pending_hits.pop_front();
      if (got.hit_axis !== want.hit_axis)
        report_mismatch($sformatf("hit_axis got %0d want %0d", got.hit_axis, want.hit_axis));
      if (got.hit_x !== want.hit_x)
        report_mismatch($sformatf("hit_x got %0d want %0d", got.hit_x, want.hit_x));
      if (got.hit_y !== want.hit_y)
        report_mismatch($sformatf("hit_y got %0d want %0d", got.hit_y, want.hit_y));
      if (got.side_x !== want.side_x)
        report_mismatch($sformatf("side_x got %h want %h", got.side_x, want.side_x));
      if (got.side_y !== want.side_y)
        report_mismatch($sformatf("side_y got %h want %h", got.side_y, want.side_y));
      if (got.left_map !== want.left_map)
        report_mismatch($sformatf("left_map got %0d want %0d", got.left_map, want.left_map));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  dgrw_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  dgrw_pkg::out_item_t out_data_o;

  ray_hit_tracker book;

  // idle rates in percent, changed per phase by the stimulus process
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // long receiver hold: requested by the stimulus, counted by the receiver
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  dda_grid_ray_walk DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // --------------------------------------------------------------------------
  // item builders
  // --------------------------------------------------------------------------
  // unused fields of a write carry random noise
  function automatic dgrw_pkg::in_item_t write_item(int cx, int cy,
                                                    logic [BYTE_W-1:0] value);
    dgrw_pkg::in_item_t it;
    it                = '0;
    it.action         = dgrw_pkg::ACT_WRITE;
    it.cell_x         = CELL_W'(cx);
    it.cell_y         = CELL_W'(cy);
    it.cell_value     = value;
    it.pos_x          = POS_W'($urandom);
    it.pos_y          = POS_W'($urandom);
    it.dir_x_negative = 1'($urandom_range(1));
    it.dir_y_negative = 1'($urandom_range(1));
    it.delta_x        = DELTA_W'($urandom);
    it.delta_y        = DELTA_W'($urandom);
    return it;
  endfunction

  function automatic dgrw_pkg::in_item_t cast_item(int cx, int cy,
                                         logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                         logic nx, logic ny,
                                         logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy);
    dgrw_pkg::in_item_t it;
    it                = '0;
    it.action         = dgrw_pkg::ACT_CAST;
    it.cell_x         = CELL_W'(cx);
    it.cell_y         = CELL_W'(cy);
    it.cell_value     = BYTE_W'($urandom);
    it.pos_x          = px;
    it.pos_y          = py;
    it.dir_x_negative = nx;
    it.dir_y_negative = ny;
    it.delta_x        = dx;
    it.delta_y        = dy;
    return it;
  endfunction

  // about a third walls, a few border bytes around the wall range
  function automatic logic [BYTE_W-1:0] random_byte();
    case ($urandom_range(9))
      0, 1, 2: return BYTE_W'($urandom_range(dgrw_pkg::CHAR_NINE - 1,
                                             dgrw_pkg::CHAR_ZERO + 1));
      3:       return $urandom_range(1) ? dgrw_pkg::CHAR_ZERO : dgrw_pkg::CHAR_NINE;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [DELTA_W-1:0] random_delta();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return DELTA_W'($urandom);
      default: return DELTA_W'($urandom_range(32'h40000, 32'h2000));
    endcase
  endfunction

  // most rays start near the corner so walls and both low edges come up often
  function automatic dgrw_pkg::in_item_t random_cast();
    int               cx, cy;
    logic [POS_W-1:0] px, py;
    if ($urandom_range(9) < 7) begin
      cx = $urandom_range(11);
      cy = $urandom_range(11);
    end else begin
      cx = $urandom_range(GRID_WIDTH - 1);
      cy = $urandom_range(GRID_HEIGHT - 1);
    end
    // mostly inside the start cell, sometimes anywhere
    px = ($urandom_range(7) == 0) ? POS_W'($urandom)
                                  : {CELL_W'(cx), FRACTION_BITS'($urandom)};
    py = ($urandom_range(7) == 0) ? POS_W'($urandom)
                                  : {CELL_W'(cy), FRACTION_BITS'($urandom)};
    return cast_item(cx, cy, px, py, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     random_delta(), random_delta());
  endfunction

  // --------------------------------------------------------------------------
  // sender: optional idle gap, then hold valid until the transaction is taken
  // --------------------------------------------------------------------------
  task automatic send_item(dgrw_pkg::in_item_t it);
    // valid only drops when a gap is actually taken
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    book.absorb_item(it);
  endtask

  // sender pause until every expected hit has come back
  task automatic drain_hits();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (book.pending() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // receiver: checks each hit taken, stalls at random or for a long hold
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) book.check_hit(out_data_o);
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   -= 1;
    end else if (hold_req) begin
      hold_req    = 1'b0;
      hold_left   = HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any transaction on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("dda_grid_ray_walk test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    dgrw_pkg::in_item_t  it;
    dgrw_pkg::out_item_t probe;
    int                  miss;
    book = new();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first phase rates also cover the directed part
    send_idle_pct = 19;
    recv_idle_pct = 72;

    // small known map near the corner; border bytes are not walls
    send_item(write_item(1, 0, dgrw_pkg::CHAR_ZERO));
    send_item(write_item(2, 0, dgrw_pkg::CHAR_NINE));
    send_item(write_item(3, 0, dgrw_pkg::CHAR_NINE - 8'd1));
    send_item(write_item(0, 1, 8'h35));
    send_item(write_item(1, 1, 8'h00));
    send_item(write_item(2, 1, 8'hFF));
    send_item(write_item(2, 2, dgrw_pkg::CHAR_ZERO + 8'd1));
    send_item(write_item(4, 0, 8'h32));

    // x only walk through the border bytes into the highest wall byte
    send_item(cast_item(0, 0, 22'h8000, 22'h8000, 1'b0, 1'b0, 32'h10000, 32'hFFFFFFFF));
    // staircase alternating axes, ends on the lowest wall byte
    send_item(cast_item(0, 0, 22'h8000, 22'h8000, 1'b0, 1'b0, 32'h10000, 32'h18000));
    // equal side distances step y, here straight off the top edge
    send_item(cast_item(0, 0, 22'h8000, 22'h8000, 1'b0, 1'b1, 32'h10000, 32'h10000));
    // off the left edge on the first step
    send_item(cast_item(0, 5, 22'h4000, 22'h58000, 1'b1, 1'b0, 32'h100, 32'hFFFFFFFF));
    // origin on the low x border of its cell and past its y cell, both start at zero
    send_item(cast_item(0, 0, 22'h0, 22'h3FFFFF, 1'b1, 1'b0, 32'h0, 32'hFFFFFFFF));
    // largest origin and deltas, off the right edge
    send_item(cast_item(63, 10, 22'h3FFFFF, 22'h0A0000, 1'b0, 1'b0,
                        32'hFFFFFFFF, 32'hFFFFFFFF));
    // zero y delta, off the bottom edge
    send_item(cast_item(20, 63, 22'h148000, 22'h3F8000, 1'b0, 1'b0, 32'hFFFFFFFF, 32'h0));
    // start cell is a wall, never tested
    send_item(cast_item(3, 0, 22'h38000, 22'h8000, 1'b0, 1'b0, 32'h10000, 32'hFFFFFFFF));
    // overwrite that wall, the first walk now runs one cell further
    send_item(write_item(3, 0, 8'h41));
    send_item(cast_item(0, 0, 22'h8000, 22'h8000, 1'b0, 1'b0, 32'h10000, 32'hFFFFFFFF));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // phase changes happen with nothing in flight
      if (n == RANDOM_ITEMS / 3) begin
        drain_hits();
        send_idle_pct = 72;
        recv_idle_pct = 19;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        drain_hits();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long receiver hold while casts keep coming, so the input backs up
      if (n == RANDOM_ITEMS / 6 || n == 5 * RANDOM_ITEMS / 6) hold_req = 1'b1;

      if ($urandom_range(99) < 30) begin
        if ($urandom_range(3) == 0)
          it = write_item($urandom_range(GRID_WIDTH - 1), $urandom_range(GRID_HEIGHT - 1),
                          random_byte());
        else
          it = write_item($urandom_range(15), $urandom_range(15), random_byte());
      end else begin
        it   = random_cast();
        miss = book.trace_ray(it, probe);
        // a ray that would read a never-written cell fills that cell instead
        if (miss >= 0) it = write_item(miss % GRID_WIDTH, miss / GRID_WIDTH, random_byte());
      end
      send_item(it);
    end

    drain_hits();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (book.mismatch_count == 0) $display("dda_grid_ray_walk test passed");
    else $display("dda_grid_ray_walk test failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/dgrw_pkg.sv
rtl/dgrw_ram.sv
rtl/dda_grid_ray_walk.sv
bench/testbench.sv
